// File: src/rsa_pkg.sv
// ----------------------------------------------------------------------------
// rsa_pkg: shared types and codes of the RPN stack ALU
// Command and status codes, the ALU operation type and the ALU control group.
// ----------------------------------------------------------------------------
`default_nettype none

package rsa_pkg;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned STATUS_W = 3;

  // Command codes
  localparam logic [KIND_W-1:0] KIND_PUSH     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POP      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK_TOP = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PEEK_BOT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ADD      = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SUB      = 3'd5;
  localparam logic [KIND_W-1:0] KIND_MUL      = 3'd6;
  localparam logic [KIND_W-1:0] KIND_DIV      = 3'd7;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_TOO_FEW  = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE    = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_DIV_ZERO = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd4;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  // Control group from the sequencer to the ALU
  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_ctrl_t;

endpackage

`default_nettype wire

// File: src/rpn_stack_alu.sv
// ----------------------------------------------------------------------------
// rpn_stack_alu: fixed-depth postfix calculator stack
// Every accepted item is decoded in DECODE. Push and the early errors go on to
// FINISH, pop and peek read the RAM in READ, and the operators read their two
// operands in RD_B and RD_A; divide by zero ends there, the rest run the ALU in
// EXEC. The next item is taken once the result is registered, even while it
// waits at the output; no new item is taken while the block is busy with one.
// Reset clears the entry count and control state; the stack RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_stack_alu
  import rsa_pkg::*;
#(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [KIND_W-1:0]            kind_i,
  input  wire logic [DATA_WIDTH-1:0]        push_value_i,
  input  wire logic [$clog2(DEPTH)-1:0]     peek_index_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [DATA_WIDTH-1:0]        result_o,
  output logic      [STATUS_W-1:0]          status_o,
  output logic      [$clog2(DEPTH+1)-1:0]   occupancy_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned DW = DATA_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_RD_B,
    S_RD_A,
    S_EXEC,
    S_FINISH
  } seq_state_e;

  seq_state_e          state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [KIND_W-1:0]   kind_q, kind_d;
  logic [DW-1:0]       value_q, value_d;
  logic [AW-1:0]       index_q, index_d;
  logic [DW-1:0]       b_q, b_d;
  logic [DW-1:0]       res_q, res_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                out_valid_q, out_valid_d;
  logic [DW-1:0]       out_result_q, out_result_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [CW-1:0]       out_occ_q, out_occ_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;

  alu_ctrl_t     alu_ctrl;
  logic          alu_start;
  alu_op_e       alu_op;
  logic          alu_done;
  logic [DW-1:0] alu_result;

  logic [CW-1:0] count_m1, count_m2, idx_ext, peek_top;
  logic          in_take;

  assign count_m1 = count_q - 1'b1;
  assign count_m2 = count_q - 2'd2;
  assign idx_ext  = CW'(index_q);
  assign peek_top = count_m1 - idx_ext;
  assign in_take  = in_valid_i && !in_stall_o;

  // Stack storage
  rsa_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Shared arithmetic unit; a from the RAM read, b from the held top word
  rsa_alu #(
    .W (DW)
  ) u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (alu_ctrl),
    .a_i      (ram_rdata),
    .b_i      (b_q),
    .done_o   (alu_done),
    .result_o (alu_result)
  );

  // Command to ALU operation
  always_comb begin
    unique case (kind_q)
      KIND_ADD: alu_op = ALU_ADD;
      KIND_SUB: alu_op = ALU_SUB;
      KIND_MUL: alu_op = ALU_MUL;
      default:  alu_op = ALU_DIV;
    endcase
  end

  assign alu_ctrl = {alu_start, alu_op};

  // Command sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    kind_d       = kind_q;
    value_d      = value_q;
    index_d      = index_q;
    b_d          = b_q;
    res_d        = res_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_result_d = out_result_q;
    out_status_d = out_status_q;
    out_occ_d    = out_occ_q;
    ram_we       = 1'b0;
    ram_waddr    = count_q[AW-1:0];
    ram_wdata    = value_q;
    ram_raddr    = count_m1[AW-1:0];
    alu_start    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          kind_d  = kind_i;
          value_d = push_value_i;
          index_d = peek_index_i;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        res_d    = '0;
        status_d = STATUS_OK;
        unique case (kind_q)
          KIND_PUSH: begin
            if (count_q == CW'(DEPTH)) begin
              status_d = STATUS_FULL;
            end else begin
              ram_we  = 1'b1;
              count_d = count_q + 1'b1;
            end
            state_d = S_FINISH;
          end
          KIND_POP: begin
            if (count_q == '0) begin
              status_d = STATUS_TOO_FEW;
              state_d  = S_FINISH;
            end else begin
              count_d = count_m1;
              state_d = S_READ;
            end
          end
          KIND_PEEK_TOP, KIND_PEEK_BOT: begin
            ram_raddr = (kind_q == KIND_PEEK_TOP) ? peek_top[AW-1:0] : index_q;
            if (idx_ext >= count_q) begin
              status_d = STATUS_RANGE;
              state_d  = S_FINISH;
            end else begin
              state_d = S_READ;
            end
          end
          default: begin
            if (count_q < CW'(2)) begin
              status_d = STATUS_TOO_FEW;
              state_d  = S_FINISH;
            end else begin
              state_d = S_RD_B;
            end
          end
        endcase
      end
      S_READ: begin
        res_d   = ram_rdata;
        state_d = S_FINISH;
      end
      S_RD_B: begin
        b_d       = ram_rdata;
        ram_raddr = count_m2[AW-1:0];
        state_d   = S_RD_A;
      end
      S_RD_A: begin
        // Divide by zero still consumes both operands
        if (kind_q == KIND_DIV && b_q == '0) begin
          status_d = STATUS_DIV_ZERO;
          count_d  = count_m2;
          state_d  = S_FINISH;
        end else begin
          alu_start = 1'b1;
          state_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (alu_done) begin
          ram_we    = 1'b1;
          ram_waddr = count_m2[AW-1:0];
          ram_wdata = alu_result;
          res_d     = alu_result;
          count_d   = count_m1;
          state_d   = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_result_d = res_q;
          out_status_d = status_q;
          out_occ_d    = count_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      kind_q       <= KIND_PUSH;
      value_q      <= '0;
      index_q      <= '0;
      b_q          <= '0;
      res_q        <= '0;
      status_q     <= STATUS_OK;
      out_valid_q  <= 1'b0;
      out_result_q <= '0;
      out_status_q <= STATUS_OK;
      out_occ_q    <= '0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      kind_q       <= kind_d;
      value_q      <= value_d;
      index_q      <= index_d;
      b_q          <= b_d;
      res_q        <= res_d;
      status_q     <= status_d;
      out_valid_q  <= out_valid_d;
      out_result_q <= out_result_d;
      out_status_q <= out_status_d;
      out_occ_q    <= out_occ_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign result_o    = out_result_q;
  assign status_o    = out_status_q;
  assign occupancy_o = out_occ_q;

  // Checks
  a_alu_done_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> (state_q == S_EXEC))
    else $error("ALU finished outside the execute step");

  a_decode_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECODE) |-> $past(in_valid_i && !in_stall_o))
    else $error("decode without an accepted item");

  a_occupancy_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (occupancy_o <= CW'(DEPTH)))
    else $error("occupancy beyond stack depth");

  a_write_below_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (count_q != '0 || state_q == S_DECODE))
    else $error("result write with an empty stack");

endmodule

`default_nettype wire

// File: src/rsa_ram.sv
// ----------------------------------------------------------------------------
// rsa_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rsa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: src/rsa_alu.sv
// ----------------------------------------------------------------------------
// rsa_alu: shared arithmetic unit of the RPN stack ALU
// Add and subtract are done in the cycle after start; shift-add multiply and
// restoring floor divide run one bit per cycle. done_o pulses for one cycle with result_o valid.
// ----------------------------------------------------------------------------
`default_nettype none

module rsa_alu
  import rsa_pkg::*;
#(
  parameter int unsigned W = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire alu_ctrl_t    ctrl_i,
  input  wire logic [W-1:0] a_i,
  input  wire logic [W-1:0] b_i,
  output logic              done_o,
  output logic      [W-1:0] result_o
);

  localparam int unsigned CntW = $clog2(W + 1);

  typedef enum logic [1:0] {
    A_IDLE,
    A_RUN,
    A_FIX
  } alu_state_e;

  alu_state_e      state_q, state_d;
  alu_op_e         op_q, op_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [W:0]      acc_q, acc_d;    // product or partial remainder
  logic [W-1:0]    ma_q, ma_d;      // multiplicand or divisor magnitude
  logic [W-1:0]    mb_q, mb_d;      // multiplier or dividend / quotient
  logic            neg_q, neg_d;
  logic            done_q, done_d;
  logic [W-1:0]    res_q, res_d;

  logic [W-1:0] mag_a, mag_b, mul_sum;
  logic [W:0]   rem_sh, rem_diff;
  logic         div_ok;

  // Operand magnitudes; the most negative word fits as unsigned
  assign mag_a = a_i[W-1] ? ({W{1'b0}} - a_i) : a_i;
  assign mag_b = b_i[W-1] ? ({W{1'b0}} - b_i) : b_i;

  // One multiply step and one divide step
  assign mul_sum  = acc_q[W-1:0] + (mb_q[0] ? ma_q : {W{1'b0}});
  assign rem_sh   = {acc_q[W-1:0], mb_q[W-1]};
  assign rem_diff = rem_sh - {1'b0, ma_q};
  assign div_ok   = ~rem_diff[W];

  // Sequencer of the unit
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    ma_d    = ma_q;
    mb_d    = mb_q;
    neg_d   = neg_q;
    done_d  = 1'b0;
    res_d   = res_q;
    unique case (state_q)
      A_IDLE: begin
        if (ctrl_i.start) begin
          op_d  = ctrl_i.op;
          cnt_d = CntW'(W);
          acc_d = '0;
          unique case (ctrl_i.op)
            ALU_ADD: begin
              res_d  = a_i + b_i;
              done_d = 1'b1;
            end
            ALU_SUB: begin
              res_d  = a_i - b_i;
              done_d = 1'b1;
            end
            ALU_MUL: begin
              ma_d    = a_i;
              mb_d    = b_i;
              state_d = A_RUN;
            end
            default: begin
              ma_d    = mag_b;
              mb_d    = mag_a;
              neg_d   = a_i[W-1] ^ b_i[W-1];
              state_d = A_RUN;
            end
          endcase
        end
      end
      A_RUN: begin
        cnt_d = cnt_q - 1'b1;
        if (op_q == ALU_MUL) begin
          acc_d = {1'b0, mul_sum};
          ma_d  = ma_q << 1;
          mb_d  = mb_q >> 1;
        end else begin
          acc_d = div_ok ? rem_diff : rem_sh;
          mb_d  = {mb_q[W-2:0], div_ok};
        end
        if (cnt_q == CntW'(1)) begin
          if (op_q == ALU_MUL) begin
            res_d   = mul_sum;
            done_d  = 1'b1;
            state_d = A_IDLE;
          end else begin
            state_d = A_FIX;
          end
        end
      end
      A_FIX: begin
        // Floor: negate, and one more down when a remainder is left
        if (neg_q) begin
          res_d = (acc_q == '0) ? ({W{1'b0}} - mb_q) : ~mb_q;
        end else begin
          res_d = mb_q;
        end
        done_d  = 1'b1;
        state_d = A_IDLE;
      end
      default: state_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      op_q    <= ALU_ADD;
      cnt_q   <= '0;
      acc_q   <= '0;
      ma_q    <= '0;
      mb_q    <= '0;
      neg_q   <= 1'b0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      ma_q    <= ma_d;
      mb_q    <= mb_d;
      neg_q   <= neg_d;
      done_q  <= done_d;
      res_q   <= res_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the RPN stack ALU
// A shadow stack predicts result, status and occupancy for every accepted
// command. Directed tests cover the empty stack and each arithmetic corner.
// A short random mix of expressions and loose commands follows, and the run
// ends by filling the stack to the top and probing it while full.
// Both sides idle in random bursts, and the output is held off for one long
// stretch so that the block backs up.
// ----------------------------------------------------------------------------

module tb;
  import rsa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH      = 1024;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IDX_W      = $clog2(DEPTH);
  localparam int unsigned OCC_W      = $clog2(DEPTH + 1);

  localparam logic [DATA_WIDTH-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [DATA_WIDTH-1:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_WIDTH-1:0] WORD_NEG_ONE = 32'hFFFF_FFFF;

  localparam int RANDOM_ITEMS  = 60;
  localparam int QUIET_ITEMS   = 150;
  localparam int HOLD_AT_ITEM  = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 50;
  localparam int STALL_LIMIT   = 5000;
  localparam int DEPTH_BOUND   = 48;

  localparam logic [KIND_W-1:0] ALL_KINDS [8] = '{
    KIND_PUSH, KIND_POP, KIND_PEEK_TOP, KIND_PEEK_BOT,
    KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV
  };

  typedef struct packed {
    logic [DATA_WIDTH-1:0] result;
    logic [STATUS_W-1:0]   status;
    logic [OCC_W-1:0]      occupancy;
  } calc_reply_t;

  // DUT signals, all known from time zero
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  logic [KIND_W-1:0]     kind       = KIND_PUSH;
  logic [DATA_WIDTH-1:0] push_value = '0;
  logic [IDX_W-1:0]      peek_index = '0;
  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  logic [DATA_WIDTH-1:0] result;
  logic [STATUS_W-1:0]   status;
  logic [OCC_W-1:0]      occupancy;

  // Shadow state and bookkeeping
  logic [DATA_WIDTH-1:0] shadow_stack [DEPTH];
  int                    shadow_depth = 0;
  calc_reply_t           pending_replies [$];
  int                    error_count  = 0;
  bit                    idle_enable  = 1'b0;
  int                    hold_request = 0;
  int                    hold_left    = 0;
  int                    burst_left   = 0;
  int                    quiet_cycles = 0;

  rpn_stack_alu #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .kind_i       (kind),
    .push_value_i (push_value),
    .peek_index_i (peek_index),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .result_o     (result),
    .status_o     (status),
    .occupancy_o  (occupancy)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow stack: apply one command and return the reply it must produce
  function automatic calc_reply_t predict_reply(logic [KIND_W-1:0] cmd,
                                                logic [DATA_WIDTH-1:0] value,
                                                logic [IDX_W-1:0] index);
    calc_reply_t           reply;
    logic signed [DATA_WIDTH-1:0] lhs;
    logic signed [DATA_WIDTH-1:0] rhs;
    logic signed [DATA_WIDTH-1:0] outcome;
    longint                quot;
    longint                rem;
    reply.result = '0;
    reply.status = STATUS_OK;
    case (cmd)
      KIND_PUSH: begin
        if (shadow_depth >= DEPTH) begin
          reply.status = STATUS_FULL;
        end else begin
          shadow_stack[shadow_depth] = value;
          shadow_depth++;
        end
      end
      KIND_POP: begin
        if (shadow_depth == 0) begin
          reply.status = STATUS_TOO_FEW;
        end else begin
          shadow_depth--;
          reply.result = shadow_stack[shadow_depth];
        end
      end
      KIND_PEEK_TOP, KIND_PEEK_BOT: begin
        if (int'(index) >= shadow_depth) begin
          reply.status = STATUS_RANGE;
        end else if (cmd == KIND_PEEK_TOP) begin
          reply.result = shadow_stack[shadow_depth - 1 - int'(index)];
        end else begin
          reply.result = shadow_stack[int'(index)];
        end
      end
      default: begin
        if (shadow_depth < 2) begin
          reply.status = STATUS_TOO_FEW;
        end else begin
          rhs = shadow_stack[shadow_depth - 1];
          lhs = shadow_stack[shadow_depth - 2];
          shadow_depth -= 2;
          outcome = '0;
          case (cmd)
            KIND_ADD: outcome = lhs + rhs;
            KIND_SUB: outcome = lhs - rhs;
            KIND_MUL: outcome = lhs * rhs;
            default: begin
              if (rhs != 0) begin
                // floor division: round toward minus infinity
                quot = longint'(lhs) / longint'(rhs);
                rem  = longint'(lhs) % longint'(rhs);
                if (rem != 0 && ((rem < 0) != (rhs < 0))) quot--;
                outcome = quot[DATA_WIDTH-1:0];
              end
            end
          endcase
          if (cmd == KIND_DIV && rhs == 0) begin
            reply.status = STATUS_DIV_ZERO;
          end else begin
            shadow_stack[shadow_depth] = outcome;
            shadow_depth++;
            reply.result = outcome;
          end
        end
      end
    endcase
    reply.occupancy = shadow_depth[OCC_W-1:0];
    return reply;
  endfunction

  // Operand values biased toward the corners
  function automatic logic [DATA_WIDTH-1:0] random_word();
    int near_zero;
    near_zero = int'($urandom_range(200)) - 100;
    case ($urandom_range(5))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2, 3:    return near_zero[DATA_WIDTH-1:0];
      default: return $urandom();
    endcase
  endfunction

  // Peek index: mostly in range, sometimes just past the top, sometimes anything
  function automatic logic [IDX_W-1:0] random_index();
    int pick;
    pick = $urandom_range(3);
    if (pick < 2 && shadow_depth > 0) return IDX_W'($urandom_range(shadow_depth - 1));
    if (pick == 2) return IDX_W'(shadow_depth);
    return IDX_W'($urandom());
  endfunction

  function automatic logic [KIND_W-1:0] random_arith();
    case ($urandom_range(3))
      0:       return KIND_ADD;
      1:       return KIND_SUB;
      2:       return KIND_MUL;
      default: return KIND_DIV;
    endcase
  endfunction

  // Offer one item, optionally after an idle burst; returns once accepted
  task automatic send_command(input logic [KIND_W-1:0] cmd,
                              input logic [DATA_WIDTH-1:0] value,
                              input logic [IDX_W-1:0] index);
    int gap;
    gap = 0;
    if (idle_enable && $urandom_range(3) == 0) gap = $urandom_range(5, 1);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    kind       = cmd;
    push_value = value;
    peek_index = index;
    do @(posedge clk); while (in_stall);
    pending_replies.push_back(predict_reply(cmd, value, index));
  endtask

  // push a, push b, then one arithmetic command
  task automatic send_expression(input logic [DATA_WIDTH-1:0] lhs,
                                 input logic [DATA_WIDTH-1:0] rhs,
                                 input logic [KIND_W-1:0] op);
    send_command(KIND_PUSH, lhs, '0);
    send_command(KIND_PUSH, rhs, '1);
    send_command(op, $urandom(), IDX_W'($urandom()));
  endtask

  // Output side: long hold when requested, else random stall bursts
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (burst_left > 0) begin
      out_stall = 1'b1;
      burst_left--;
    end else if (idle_enable && $urandom_range(4) == 0) begin
      out_stall  = 1'b1;
      burst_left = $urandom_range(4, 0);
    end else begin
      out_stall = 1'b0;
    end
  end

  // Compare each accepted reply with the oldest prediction
  always @(posedge clk) begin
    calc_reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected reply: result %0d status %0d occupancy %0d",
               $signed(result), status, occupancy);
        error_count++;
      end else begin
        want = pending_replies.pop_front();
        if (result !== want.result) begin
          $error("result: expected %0d, got %0d", $signed(want.result), $signed(result));
          error_count++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          error_count++;
        end
        if (occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy);
          error_count++;
        end
      end
    end
  end

  // Watchdog: too long without any handshake on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Pop, both peeks and add on an empty stack, then one entry
  task automatic test_empty_stack();
    send_command(KIND_POP, '0, '0);
    send_command(KIND_PEEK_TOP, '0, '0);
    send_command(KIND_PEEK_BOT, '0, '0);
    send_command(KIND_ADD, '0, '0);
    send_command(KIND_PUSH, 32'd42, '0);
    send_command(KIND_MUL, '0, '0);
    send_command(KIND_PEEK_TOP, '0, 10'd1);
    send_command(KIND_PEEK_BOT, '0, '0);
    send_command(KIND_POP, '0, '0);
  endtask

  // Wrap-around, floor division and the divide corners
  task automatic test_arithmetic();
    send_expression(WORD_MAX, 32'd1, KIND_ADD);
    send_expression(WORD_MIN, 32'd1, KIND_SUB);
    send_expression(32'h0001_0000, 32'h0001_0000, KIND_MUL);
    send_expression(32'd7, -32'sd2, KIND_DIV);
    send_expression(-32'sd7, 32'd2, KIND_DIV);
    send_expression(WORD_MIN, WORD_NEG_ONE, KIND_DIV);
    send_expression(32'd5, 32'd0, KIND_DIV);
    send_expression(WORD_MIN, WORD_MIN, KIND_SUB);
  endtask

  // Fill to the top, push on full and peek the far ends; no idling at the end
  task automatic test_full_stack();
    idle_enable = 1'b1;
    while (shadow_depth < DEPTH) begin
      if (shadow_depth >= DEPTH - QUIET_ITEMS) idle_enable = 1'b0;
      send_command(KIND_PUSH, random_word(), IDX_W'($urandom()));
    end
    idle_enable = 1'b0;
    send_command(KIND_PUSH, WORD_MIN, '0);
    send_command(KIND_PUSH, WORD_MAX, '1);
    send_command(KIND_PEEK_TOP, '0, '1);
    send_command(KIND_PEEK_BOT, '1, '1);
    send_command(KIND_PEEK_TOP, '1, '0);
    send_command(KIND_PEEK_BOT, '0, '0);
  endtask

  // Mostly well-formed expressions, plus loose and broken commands
  task automatic test_random_mix();
    int                    sent;
    logic [KIND_W-1:0]     op;
    logic [DATA_WIDTH-1:0] lhs;
    logic [DATA_WIDTH-1:0] rhs;
    bit                    hold_done;
    sent      = 0;
    hold_done = 1'b0;
    idle_enable = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      if (!hold_done && sent >= HOLD_AT_ITEM) begin
        // back up the block while the sender keeps offering
        hold_request = HOLD_CYCLES;
        hold_done    = 1'b1;
      end
      if ($urandom_range(9) < 6 && shadow_depth <= DEPTH_BOUND) begin
        op  = random_arith();
        lhs = random_word();
        rhs = random_word();
        if (op == KIND_DIV) begin
          case ($urandom_range(7))
            0:       rhs = '0;
            1: begin
              lhs = WORD_MIN;
              rhs = WORD_NEG_ONE;
            end
            default: ;
          endcase
        end
        send_expression(lhs, rhs, op);
        sent += 3;
      end else begin
        if (shadow_depth > DEPTH_BOUND)
          op = ($urandom_range(1) == 0) ? KIND_POP : random_arith();
        else
          op = ALL_KINDS[$urandom_range(7)];
        send_command(op, random_word(), random_index());
        sent++;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_stack();
    test_arithmetic();
    test_random_mix();
    test_full_stack();

    // drain: no more items, wait for every reply, then let the block settle
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
